### rtl/core/gocs_pkg.sv
`timescale 1ns / 1ps

package gocs_pkg;

   localparam int JUNK_COUNT_DEF = 16;
   localparam int SUM_COUNT_DEF  = 128;

   localparam int AXES        = 3;
   localparam int SAMPLE_W    = 16;
   localparam int CNT_W       = 8;
   localparam int RANGE_W     = 2;
   localparam int FS_W        = 15;
   localparam int RATE_PROD_W = 30;
   localparam int RATE_SHIFT  = 15;
   localparam int RATE_Q_W    = 15;
   localparam int RATE_R_W    = 16;

   // Rates divide by 2^15 - 1.
   localparam logic [RATE_R_W-1:0] RATE_DIVISOR = RATE_R_W'((1 << RATE_SHIFT) - 1);

   localparam logic FUNC_SAMPLE    = 1'b0;
   localparam logic FUNC_CALIBRATE = 1'b1;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_JUNK = 2'd1,
      PH_SUM  = 2'd2
   } cal_phase_type;

   typedef enum logic [RANGE_W-1:0] {
      RANGE_310  = 2'd0,
      RANGE_500  = 2'd1,
      RANGE_2000 = 2'd2
   } range_type;

   typedef struct packed {
      logic calibrating;
      logic updated;
      logic busy;
   } cal_status_type;

   // Full scale in 1/16 dps units, so the rate is fs16 * corr / 32767.
   function automatic logic [FS_W-1:0] full_scale16(input logic [RANGE_W-1:0] mode);
      logic [FS_W-1:0] fs;
      case (mode)
         RANGE_310: fs = FS_W'(16 * 310);
         RANGE_500: fs = FS_W'(16 * 500);
         default:   fs = FS_W'(16 * 2000);
      endcase
      return fs;
   endfunction

endpackage

### rtl/core/gyro_offset_calibrate_scale_unit.sv
`timescale 1ns / 1ps
// A result passes the input register, the multiply stage and the result register
// in order, and each stage holds while the stage after it is full and not taken.
// Throughput: one item per cycle while results are taken; after the item that
// completes calibration, no item is taken while the offset divider runs.
// Reset: synchronous, clears offsets, sums, calibration phase and range select.

module gyro_offset_calibrate_scale_unit #(
   parameter int JUNK_COUNT = gocs_pkg::JUNK_COUNT_DEF,
   parameter int SUM_COUNT  = gocs_pkg::SUM_COUNT_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_func,
   input  logic signed [gocs_pkg::SAMPLE_W-1:0]  req_raw_x,
   input  logic signed [gocs_pkg::SAMPLE_W-1:0]  req_raw_y,
   input  logic signed [gocs_pkg::SAMPLE_W-1:0]  req_raw_z,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [gocs_pkg::SAMPLE_W-1:0]  rsp_corr_x,
   output logic signed [gocs_pkg::SAMPLE_W-1:0]  rsp_corr_y,
   output logic signed [gocs_pkg::SAMPLE_W-1:0]  rsp_corr_z,
   output logic signed [gocs_pkg::SAMPLE_W-1:0]  rsp_dps_x,
   output logic signed [gocs_pkg::SAMPLE_W-1:0]  rsp_dps_y,
   output logic signed [gocs_pkg::SAMPLE_W-1:0]  rsp_dps_z,
   output logic                                  rsp_calibrating,
   output logic                                  rsp_offsets_updated,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic        [gocs_pkg::RANGE_W-1:0]   csr_range_mode
);

   logic [gocs_pkg::RANGE_W-1:0] range_ff;
   logic s1_vld_ff, s2_vld_ff, s3_vld_ff;
   logic s1_ready, s2_ready, s3_ready;
   logic s2_load, s3_load;
   logic accept;
   logic cal1_ff, cal2_ff, cal3_ff;
   logic upd1_ff, upd2_ff, upd3_ff;

   gocs_pkg::cal_status_type cal_status;
   logic signed [gocs_pkg::SAMPLE_W-1:0] offset_x, offset_y, offset_z;

   assign s3_ready  = !s3_vld_ff || rsp_ready;
   assign s2_ready  = !s2_vld_ff || s3_ready;
   assign s1_ready  = !s1_vld_ff || s2_ready;
   assign s2_load   = s2_ready && s1_vld_ff;
   assign s3_load   = s3_ready && s2_vld_ff;
   assign req_ready = s1_ready && !cal_status.busy;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff  <= gocs_pkg::RANGE_310;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            range_ff <= csr_range_mode;
         end
         if (s1_ready) begin
            s1_vld_ff <= accept;
         end
         if (s2_ready) begin
            s2_vld_ff <= s1_vld_ff;
         end
         if (s3_ready) begin
            s3_vld_ff <= s2_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cal1_ff <= cal_status.calibrating;
         upd1_ff <= cal_status.updated;
      end
      if (s2_load) begin
         cal2_ff <= cal1_ff;
         upd2_ff <= upd1_ff;
      end
      if (s3_load) begin
         cal3_ff <= cal2_ff;
         upd3_ff <= upd2_ff;
      end
   end

   gocs_cal_ctrl #(
      .JUNK_COUNT (JUNK_COUNT),
      .SUM_COUNT  (SUM_COUNT)
   ) u_cal_ctrl (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .func     (req_func),
      .raw_x    (req_raw_x),
      .raw_y    (req_raw_y),
      .raw_z    (req_raw_z),
      .offset_x (offset_x),
      .offset_y (offset_y),
      .offset_z (offset_z),
      .status   (cal_status)
   );

   gocs_rate_scale u_scale_x (
      .clock      (clock),
      .s1_load    (accept),
      .s2_load    (s2_load),
      .s3_load    (s3_load),
      .cmd        (req_func),
      .raw        (req_raw_x),
      .offset     (offset_x),
      .range_mode (range_ff),
      .corr       (rsp_corr_x),
      .dps        (rsp_dps_x)
   );

   gocs_rate_scale u_scale_y (
      .clock      (clock),
      .s1_load    (accept),
      .s2_load    (s2_load),
      .s3_load    (s3_load),
      .cmd        (req_func),
      .raw        (req_raw_y),
      .offset     (offset_y),
      .range_mode (range_ff),
      .corr       (rsp_corr_y),
      .dps        (rsp_dps_y)
   );

   gocs_rate_scale u_scale_z (
      .clock      (clock),
      .s1_load    (accept),
      .s2_load    (s2_load),
      .s3_load    (s3_load),
      .cmd        (req_func),
      .raw        (req_raw_z),
      .offset     (offset_z),
      .range_mode (range_ff),
      .corr       (rsp_corr_z),
      .dps        (rsp_dps_z)
   );

   assign rsp_valid           = s3_vld_ff;
   assign rsp_calibrating     = cal3_ff;
   assign rsp_offsets_updated = upd3_ff;

   // The item after a completing one must wait for the new offsets.
   a_hold_after_update: assert property (@(posedge clock) disable iff (reset)
      (accept && cal_status.updated) |=> !req_ready)
      else $error("item accepted before offsets were reloaded");

   // Offsets move only while the divider is running.
   a_offset_stable: assert property (@(posedge clock) disable iff (reset)
      !cal_status.busy |=> $stable(offset_x) && $stable(offset_y) && $stable(offset_z))
      else $error("offset changed outside the divider pass");

   a_update_in_cal: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_offsets_updated) |-> rsp_calibrating)
      else $error("offsets_updated without calibrating");

   a_zero_rate: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_corr_x == '0) |-> rsp_dps_x == '0)
      else $error("nonzero rate for a zero corrected value");

endmodule

### rtl/core/gocs_rate_scale.sv
`timescale 1ns / 1ps

module gocs_rate_scale (
   input  logic                                  clock,
   input  logic                                  s1_load,
   input  logic                                  s2_load,
   input  logic                                  s3_load,
   input  logic                                  cmd,
   input  logic signed [gocs_pkg::SAMPLE_W-1:0]  raw,
   input  logic signed [gocs_pkg::SAMPLE_W-1:0]  offset,
   input  logic        [gocs_pkg::RANGE_W-1:0]   range_mode,
   output logic signed [gocs_pkg::SAMPLE_W-1:0]  corr,
   output logic signed [gocs_pkg::SAMPLE_W-1:0]  dps
);

   logic signed [gocs_pkg::SAMPLE_W-1:0]    corr1_ff, corr1_in;
   logic signed [gocs_pkg::SAMPLE_W-1:0]    corr2_ff;
   logic                                    neg2_ff;
   logic        [gocs_pkg::RATE_PROD_W-1:0] prod2_ff, prod2_in;
   logic signed [gocs_pkg::SAMPLE_W-1:0]    corr3_ff;
   logic signed [gocs_pkg::SAMPLE_W-1:0]    dps3_ff, dps3_in;

   logic [gocs_pkg::SAMPLE_W-1:0]             mag;
   logic [gocs_pkg::SAMPLE_W+gocs_pkg::FS_W-1:0] prod_full;
   logic [gocs_pkg::RATE_Q_W-1:0]             q0;
   logic [gocs_pkg::RATE_R_W-1:0]             rem;
   logic [gocs_pkg::RATE_Q_W-1:0]             quo;

   // A command item carries zeros, which also gives a zero rate.
   assign corr1_in = (cmd == gocs_pkg::FUNC_CALIBRATE) ? '0 :
                     gocs_pkg::SAMPLE_W'(raw - offset);

   always_comb begin
      mag       = corr1_ff[gocs_pkg::SAMPLE_W-1] ? gocs_pkg::SAMPLE_W'(-corr1_ff) : corr1_ff;
      prod_full = mag * gocs_pkg::full_scale16(range_mode);
      prod2_in  = prod_full[gocs_pkg::RATE_PROD_W-1:0];
   end

   // p / (2^15 - 1) is floor(p / 2^15) or one more; the remainder against
   // the floor quotient stays below twice the divisor.
   always_comb begin
      q0  = prod2_ff[gocs_pkg::RATE_SHIFT +: gocs_pkg::RATE_Q_W];
      rem = {1'b0, prod2_ff[gocs_pkg::RATE_SHIFT-1:0]} + {1'b0, q0};
      quo = q0 + gocs_pkg::RATE_Q_W'(rem >= gocs_pkg::RATE_DIVISOR);
      dps3_in = neg2_ff ? -gocs_pkg::SAMPLE_W'(quo) : gocs_pkg::SAMPLE_W'(quo);
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         corr1_ff <= corr1_in;
      end
      if (s2_load) begin
         corr2_ff <= corr1_ff;
         neg2_ff  <= corr1_ff[gocs_pkg::SAMPLE_W-1];
         prod2_ff <= prod2_in;
      end
      if (s3_load) begin
         corr3_ff <= corr2_ff;
         dps3_ff  <= dps3_in;
      end
   end

   assign corr = corr3_ff;
   assign dps  = dps3_ff;

endmodule

### rtl/core/gocs_cal_ctrl.sv
`timescale 1ns / 1ps

module gocs_cal_ctrl #(
   parameter int JUNK_COUNT = gocs_pkg::JUNK_COUNT_DEF,
   parameter int SUM_COUNT  = gocs_pkg::SUM_COUNT_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  accept,
   input  logic                                  func,
   input  logic signed [gocs_pkg::SAMPLE_W-1:0]  raw_x,
   input  logic signed [gocs_pkg::SAMPLE_W-1:0]  raw_y,
   input  logic signed [gocs_pkg::SAMPLE_W-1:0]  raw_z,
   output logic signed [gocs_pkg::SAMPLE_W-1:0]  offset_x,
   output logic signed [gocs_pkg::SAMPLE_W-1:0]  offset_y,
   output logic signed [gocs_pkg::SAMPLE_W-1:0]  offset_z,
   output gocs_pkg::cal_status_type              status
);

   localparam int CLOG_D      = $clog2(SUM_COUNT);
   localparam int SUM_W       = gocs_pkg::SAMPLE_W + CLOG_D;
   localparam int RECIP_SHIFT = SUM_W + CLOG_D;
   localparam int M_W         = SUM_W + 1;
   localparam int PROD_W      = SUM_W + M_W;
   localparam longint unsigned RECIP_FULL =
      ((64'd1 << RECIP_SHIFT) + 64'(SUM_COUNT) - 64'd1) / 64'(SUM_COUNT);
   localparam logic [M_W-1:0] RECIP = M_W'(RECIP_FULL);

   localparam int AX = gocs_pkg::AXES;

   gocs_pkg::cal_phase_type           phase_ff, phase_in;
   logic [gocs_pkg::CNT_W-1:0]        count_ff, count_in, count_inc;
   logic signed [SUM_W-1:0]           sum_ff [AX];
   logic signed [SUM_W-1:0]           sum_in [AX];
   logic signed [gocs_pkg::SAMPLE_W-1:0] raw [AX];
   logic signed [gocs_pkg::SAMPLE_W-1:0] offset_ff [AX];
   logic                              complete;

   logic                              abs_vld_ff, mul_vld_ff, load_vld_ff;
   logic                              sign_ff [AX];
   logic [SUM_W-1:0]                  mag_ff [AX];
   logic [PROD_W-1:0]                 prod_ff [AX];
   logic [gocs_pkg::SAMPLE_W-1:0]     quo [AX];

   assign raw[0] = raw_x;
   assign raw[1] = raw_y;
   assign raw[2] = raw_z;

   always_comb begin
      phase_in           = phase_ff;
      count_in           = count_ff;
      sum_in             = sum_ff;
      complete           = 1'b0;
      status.calibrating = 1'b0;
      status.updated     = 1'b0;
      status.busy        = abs_vld_ff | mul_vld_ff | load_vld_ff;
      count_inc          = count_ff + gocs_pkg::CNT_W'(1);
      if (accept) begin
         if (func == gocs_pkg::FUNC_CALIBRATE) begin
            status.calibrating = 1'b1;
            count_in           = '0;
            for (int a = 0; a < AX; a++) begin
               sum_in[a] = '0;
            end
            phase_in = (JUNK_COUNT == 0) ? gocs_pkg::PH_SUM : gocs_pkg::PH_JUNK;
         end else begin
            case (phase_ff)
               gocs_pkg::PH_JUNK: begin
                  status.calibrating = 1'b1;
                  if (count_inc >= gocs_pkg::CNT_W'(JUNK_COUNT)) begin
                     phase_in = gocs_pkg::PH_SUM;
                     count_in = '0;
                     for (int a = 0; a < AX; a++) begin
                        sum_in[a] = '0;
                     end
                  end else begin
                     count_in = count_inc;
                  end
               end
               gocs_pkg::PH_SUM: begin
                  status.calibrating = 1'b1;
                  for (int a = 0; a < AX; a++) begin
                     sum_in[a] = sum_ff[a] + SUM_W'(raw[a]);
                  end
                  if (count_inc >= gocs_pkg::CNT_W'(SUM_COUNT)) begin
                     phase_in       = gocs_pkg::PH_IDLE;
                     count_in       = '0;
                     complete       = 1'b1;
                     status.updated = 1'b1;
                  end else begin
                     count_in = count_inc;
                  end
               end
               default: begin
                  phase_in = gocs_pkg::PH_IDLE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= gocs_pkg::PH_IDLE;
         count_ff    <= '0;
         abs_vld_ff  <= 1'b0;
         mul_vld_ff  <= 1'b0;
         load_vld_ff <= 1'b0;
         for (int a = 0; a < AX; a++) begin
            sum_ff[a]    <= '0;
            offset_ff[a] <= '0;
         end
      end else begin
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         abs_vld_ff  <= complete;
         mul_vld_ff  <= abs_vld_ff;
         load_vld_ff <= mul_vld_ff;
         for (int a = 0; a < AX; a++) begin
            sum_ff[a] <= sum_in[a];
            if (load_vld_ff) begin
               offset_ff[a] <= sign_ff[a] ? -quo[a] : quo[a];
            end
         end
      end
   end

   // Sum / SUM_COUNT by a reciprocal multiply on the magnitude, so that
   // the quotient truncates toward zero. The magnitude, product and offset
   // are registered in turn after the completing item, while input holds off.
   always_ff @(posedge clock) begin
      for (int a = 0; a < AX; a++) begin
         if (abs_vld_ff) begin
            sign_ff[a] <= sum_ff[a][SUM_W-1];
            mag_ff[a]  <= sum_ff[a][SUM_W-1] ? SUM_W'(-sum_ff[a]) : sum_ff[a];
         end
         if (mul_vld_ff) begin
            prod_ff[a] <= mag_ff[a] * RECIP;
         end
      end
   end

   always_comb begin
      for (int a = 0; a < AX; a++) begin
         quo[a] = prod_ff[a][RECIP_SHIFT +: gocs_pkg::SAMPLE_W];
      end
   end

   assign offset_x = offset_ff[0];
   assign offset_y = offset_ff[1];
   assign offset_z = offset_ff[2];

endmodule
